@@ hw/rtl/nmrb_pkg.sv @@
`default_nettype none
package nmrb_pkg;

   localparam int MaxNmerLen   = 3;
   localparam int AlphabetSize = 4;
   localparam logic [31:0] RateReset     = 32'd42949673;
   localparam logic [31:0] MarginalReset = 32'd1073741824;

   localparam int OpW    = 3;
   localparam int IdxW   = 9;
   localparam int ValW   = 32;
   localparam int CodeW  = 6;
   localparam int EntryW = 37;
   localparam int CsrIdxW = 3;

   typedef enum logic [OpW-1:0] {
      OP_WRITE_RATE = 3'd0,
      OP_WRITE_FREQ = 3'd1,
      OP_FILL_FREQ  = 3'd2,
      OP_BUILD      = 3'd3,
      OP_READ       = 3'd4
   } op_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_NMER_LENGTH = 3'd0,
      CSR_MARGINAL_A  = 3'd1,
      CSR_MARGINAL_C  = 3'd2,
      CSR_MARGINAL_G  = 3'd3,
      CSR_MARGINAL_T  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [OpW-1:0]   operation;
      logic [IdxW-1:0]  item_index;
      logic [ValW-1:0]  item_value;
      logic [CodeW-1:0] row_code;
      logic [CodeW-1:0] col_code;
   } req_payload_type;

   typedef struct packed {
      logic signed [EntryW-1:0] entry_value;
      logic                     status;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RCLR,
      ST_FILL_RD,
      ST_FILL_MUL,
      ST_CLR,
      ST_PAIR_RD,
      ST_PAIR_LO,
      ST_PAIR_HI,
      ST_DIAG,
      ST_DIAG_WR,
      ST_READ,
      ST_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic rate_clear;
      logic capture;
      logic single;
      logic fill_rd;
      logic fill_mul;
      logic clr;
      logic pair_rd;
      logic pair_lo;
      logic pair_hi;
      logic diag;
      logic diag_wr;
      logic read;
      logic start;
   } cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic rclr_last;
      logic fill_last_digit;
      logic fill_last;
      logic clr_last;
      logic pair_skip;
      logic pair_last;
      logic diag_last_col;
      logic diag_last;
      logic op_is_fill;
      logic op_is_build;
      logic op_is_read;
   } sts_type;

endpackage
`default_nettype wire

@@ hw/rtl/nmrb_ctrl.sv @@
`default_nettype none
module nmrb_ctrl
   import nmrb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   input  wire sts_type sts,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      take;

   assign take = req_valid && !req_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RCLR:     if (sts.rclr_last) state_in = ST_IDLE;
         ST_IDLE:     if (take) begin
            if (sts.op_is_fill) state_in = ST_FILL_RD;
            else if (sts.op_is_build) state_in = ST_CLR;
            else if (sts.op_is_read) state_in = ST_READ;
            else state_in = ST_DONE;
         end
         ST_FILL_RD:  state_in = ST_FILL_MUL;
         ST_FILL_MUL: if (sts.fill_last_digit && sts.fill_last) state_in = ST_DONE;
                      else state_in = ST_FILL_RD;
         ST_CLR:      if (sts.clr_last) state_in = ST_PAIR_RD;
         ST_PAIR_RD:  if (sts.pair_skip) begin
            if (sts.pair_last) state_in = ST_DIAG;
         end else state_in = ST_PAIR_LO;
         ST_PAIR_LO:  state_in = ST_PAIR_HI;
         ST_PAIR_HI:  state_in = sts.pair_last ? ST_DIAG : ST_PAIR_RD;
         ST_DIAG:     if (sts.diag_last_col) state_in = ST_DIAG_WR;
         ST_DIAG_WR:  state_in = sts.diag_last ? ST_DONE : ST_DIAG;
         ST_READ:     state_in = ST_DONE;
         ST_DONE:     if (!rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_RCLR:     cmd.rate_clear = 1'b1;
         ST_IDLE:     begin
            cmd.capture = take;
            cmd.single  = take;
            cmd.start   = take;
         end
         ST_FILL_RD:  cmd.fill_rd = 1'b1;
         ST_FILL_MUL: cmd.fill_mul = 1'b1;
         ST_CLR:      cmd.clr = 1'b1;
         ST_PAIR_RD:  cmd.pair_rd = 1'b1;
         ST_PAIR_LO:  cmd.pair_lo = 1'b1;
         ST_PAIR_HI:  cmd.pair_hi = 1'b1;
         ST_DIAG:     cmd.diag = 1'b1;
         ST_DIAG_WR:  cmd.diag_wr = 1'b1;
         ST_READ:     cmd.read = 1'b1;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_RCLR;
      else state_ff <= state_in;
   end

   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result shown while input open");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.fill_rd, cmd.fill_mul, cmd.clr, cmd.pair_rd, cmd.pair_lo,
                cmd.pair_hi, cmd.diag, cmd.diag_wr, cmd.read}))
      else $error("conflicting commands");

endmodule
`default_nettype wire

@@ hw/rtl/nmrb_datapath.sv @@
`default_nettype none
module nmrb_datapath
   import nmrb_pkg::*;
#(
   parameter int MAX_NMER_LEN = MaxNmerLen
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [ValW-1:0] csr_data,
   input  wire cmd_type         cmd,
   output sts_type              sts,
   output rsp_payload_type      rsp_data
);

   localparam int CW    = 2 * MAX_NMER_LEN;            // code width
   localparam int Count = 1 << CW;
   localparam int RDep  = 6 * MAX_NMER_LEN * (Count / 4);
   localparam int RW    = $clog2(RDep);
   localparam int MW    = 2 * CW;
   localparam int LW    = $clog2(MAX_NMER_LEN + 1);

   // Configuration registers.
   logic [1:0]      len_ff;
   logic [ValW-1:0] marg_ff [4];
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= 2'd1;
         for (int b = 0; b < 4; b++) marg_ff[b] <= MarginalReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NMER_LENGTH: len_ff <= csr_data[1:0];
            CSR_MARGINAL_A:  marg_ff[0] <= csr_data;
            CSR_MARGINAL_C:  marg_ff[1] <= csr_data;
            CSR_MARGINAL_G:  marg_ff[2] <= csr_data;
            CSR_MARGINAL_T:  marg_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective length and derived sizes.
   logic [LW-1:0]   n;
   logic [CW:0]     count;
   logic [RW+1:0]   rates;
   always_comb begin
      if (len_ff == 2'd0) n = LW'(1);
      else if (32'(len_ff) > MAX_NMER_LEN) n = LW'(MAX_NMER_LEN);
      else n = LW'(len_ff);
      count = (CW+1)'(1) << (2 * n);
      rates = (RW+2)'(6 * 32'(n)) * (RW+2)'(count >> 2);
   end

   // Captured item.
   req_payload_type item_ff;
   always_ff @(posedge clock) if (cmd.capture) item_ff <= req_data;

   // Memories.
   logic [ValW-1:0]   rate_mem [RDep];
   logic [ValW-1:0]   freq_mem [Count];
   logic [EntryW-1:0] mat_mem  [Count*Count];
   logic [ValW-1:0]   rate_rd_ff, fi_rd_ff, fj_rd_ff;
   logic [EntryW-1:0] mat_rd_ff;

   // Walk counters.
   logic [RW:0]   rclr_ff;
   logic [CW:0]   i_ff, j_ff;
   logic [MW:0]   clr_ff;
   logic [RW:0]   k_ff;
   logic [LW-1:0] dig_ff;
   logic [ValW-1:0] prod_ff;
   logic [EntryW-1:0] sum_ff;

   // Fill: one marginal per digit, first digit most significant.
   logic [1:0] fill_sym;
   logic [63:0] fill_full;
   assign fill_sym = 2'(i_ff[CW-1:0] >> (2 * (n - LW'(1) - dig_ff)));
   assign fill_full = 64'(prod_ff) * 64'(marg_ff[fill_sym]);

   // One-digit-apart test between i and j.
   logic [CW-1:0] dx;
   logic [LW:0]   ndiff;
   always_comb begin
      dx = i_ff[CW-1:0] ^ j_ff[CW-1:0];
      ndiff = '0;
      for (int p = 0; p < MAX_NMER_LEN; p++)
         if (dx[2*p +: 2] != 2'd0) ndiff = ndiff + (LW+1)'(1);
   end

   logic [CW:0] j_next, i_next;
   logic        pair_end;
   always_comb begin
      j_next = j_ff + (CW+1)'(1);
      i_next = i_ff + (CW+1)'(1);
      pair_end = (j_next >= count) && (i_next + (CW+1)'(1) >= count);
   end

   // The rate of the current pair is held in rate_rd_ff while k stays put.
   logic [ValW-1:0] pair_rate;
   logic [63:0] mul_lo, mul_hi;
   assign pair_rate = (32'(k_ff) < RDep) ? rate_rd_ff : '0;
   assign mul_lo = 64'(pair_rate) * 64'(fj_rd_ff);
   assign mul_hi = 64'(pair_rate) * 64'(fi_rd_ff);

   logic [MW-1:0] ij_addr, ji_addr, rd_addr;
   assign ij_addr = {i_ff[CW-1:0], j_ff[CW-1:0]};
   assign ji_addr = {j_ff[CW-1:0], i_ff[CW-1:0]};
   assign rd_addr = {item_ff.row_code[CW-1:0], item_ff.col_code[CW-1:0]};

   // Diagonal accumulate uses the read of column j-1.
   logic [CW:0] jp;
   logic [EntryW:0] sum_next_prev;
   assign jp = j_ff - (CW+1)'(1);
   assign sum_next_prev = (EntryW+1)'(sum_ff) +
                          ((jp != i_ff) ? (EntryW+1)'(mat_rd_ff) : '0);

   logic idx_ok_rate, idx_ok_freq, code_ok;
   assign idx_ok_rate = ((RW+2)'(item_ff.item_index) < rates) &&
                        (32'(item_ff.item_index) < RDep);
   assign idx_ok_freq = (CW+1)'(item_ff.item_index) < count &&
                        32'(item_ff.item_index) < Count;
   assign code_ok = (32'(item_ff.row_code) < 32'(count)) &&
                    (32'(item_ff.col_code) < 32'(count));

   // Rate memory: clearing pass, single writes, pair reads.
   always_ff @(posedge clock) begin
      if (cmd.rate_clear) rate_mem[RW'(rclr_ff)] <= RateReset;
      else if (cmd.single && req_data.operation == OP_WRITE_RATE &&
               ((RW+2)'(req_data.item_index) < rates) &&
               (32'(req_data.item_index) < RDep))
         rate_mem[RW'(req_data.item_index)] <= req_data.item_value;
      rate_rd_ff <= rate_mem[RW'(k_ff)];
   end

   // Frequency memory: two read ports for i and j.
   always_ff @(posedge clock) begin
      if (cmd.fill_mul && dig_ff == n - LW'(1))
         freq_mem[i_ff[CW-1:0]] <= (dig_ff == '0) ? prod_ff : fill_full[63:32];
      else if (cmd.single && req_data.operation == OP_WRITE_FREQ &&
               (CW+1)'(req_data.item_index) < count &&
               32'(req_data.item_index) < Count)
         freq_mem[CW'(req_data.item_index)] <= req_data.item_value;
      fi_rd_ff <= freq_mem[i_ff[CW-1:0]];
      fj_rd_ff <= freq_mem[j_ff[CW-1:0]];
   end

   // Matrix memory: one write, one read per cycle. The read data only moves
   // for a read item or a diagonal walk, so a waiting result stays put.
   always_ff @(posedge clock) begin
      if (cmd.clr) mat_mem[MW'(clr_ff)] <= '0;
      else if (cmd.pair_lo) mat_mem[ij_addr] <= EntryW'(mul_lo[63:32]);
      else if (cmd.pair_hi) mat_mem[ji_addr] <= EntryW'(mul_hi[63:32]);
      else if (cmd.diag_wr)
         mat_mem[{i_ff[CW-1:0], i_ff[CW-1:0]}] <= EntryW'(0) - sum_ff;
      if (cmd.read) mat_rd_ff <= mat_mem[rd_addr];
      else if (cmd.diag) mat_rd_ff <= mat_mem[{i_ff[CW-1:0], j_ff[CW-1:0]}];
   end

   // Sequencing counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         rclr_ff <= '0;
      end else if (cmd.rate_clear) begin
         rclr_ff <= rclr_ff + (RW+1)'(1);
      end
      if (cmd.start) begin
         i_ff <= '0; j_ff <= (CW+1)'(1); dig_ff <= '0; clr_ff <= '0;
         k_ff <= '0; sum_ff <= '0;
         prod_ff <= marg_ff[0];
      end
      if (cmd.fill_rd) begin
         if (dig_ff == '0) prod_ff <= marg_ff[fill_sym];
      end
      if (cmd.fill_mul) begin
         if (dig_ff != '0) prod_ff <= fill_full[63:32];
         if (dig_ff == n - LW'(1)) begin
            dig_ff <= '0;
            i_ff <= i_next;
         end else dig_ff <= dig_ff + LW'(1);
      end
      if (cmd.clr) begin
         clr_ff <= clr_ff + (MW+1)'(1);
         if (clr_ff == (MW+1)'(Count*Count - 1)) begin
            i_ff <= '0; j_ff <= (CW+1)'(1);
         end
      end
      if (cmd.pair_rd && ndiff != (LW+1)'(1)) begin
         if (pair_end) begin
            i_ff <= '0; j_ff <= '0;
         end else if (j_next >= count) begin
            i_ff <= i_next; j_ff <= i_next + (CW+1)'(1);
         end else j_ff <= j_next;
      end
      if (cmd.pair_hi) begin
         k_ff <= k_ff + (RW+1)'(1);
         if (pair_end) begin
            i_ff <= '0; j_ff <= '0; sum_ff <= '0;
         end else if (j_next >= count) begin
            i_ff <= i_next; j_ff <= i_next + (CW+1)'(1);
         end else j_ff <= j_next;
      end
      if (cmd.diag) begin
         // mat_rd_ff holds the read of the previous j; accumulate the previous column.
         if (j_ff != '0)
            sum_ff <= (sum_next_prev > (EntryW+1)'(37'h1000000000)) ?
                      37'h1000000000 : EntryW'(sum_next_prev);
         j_ff <= j_next;
      end
      if (cmd.diag_wr) begin
         i_ff <= i_next; j_ff <= '0; sum_ff <= '0;
      end
   end

   // Status to the controller.
   always_comb begin
      sts.rclr_last       = (rclr_ff == (RW+1)'(RDep - 1));
      sts.fill_last_digit = (dig_ff == n - LW'(1));
      sts.fill_last       = (i_next >= count);
      sts.clr_last        = (clr_ff == (MW+1)'(Count*Count - 1));
      sts.pair_skip       = (ndiff != (LW+1)'(1)) || (i_ff + (CW+1)'(1) >= count);
      sts.pair_last       = pair_end || (i_ff + (CW+1)'(1) >= count);
      sts.diag_last_col   = (j_ff == count);
      sts.diag_last       = (i_next >= count);
      sts.op_is_fill      = (req_data.operation == OP_FILL_FREQ);
      sts.op_is_build     = (req_data.operation == OP_BUILD);
      sts.op_is_read      = (req_data.operation == OP_READ);
   end

   // Result.
   always_comb begin
      rsp_data = '0;
      unique case (item_ff.operation)
         OP_WRITE_RATE: rsp_data.status = !idx_ok_rate;
         OP_WRITE_FREQ: rsp_data.status = !idx_ok_freq;
         OP_READ: begin
            rsp_data.status = !code_ok;
            if (code_ok) rsp_data.entry_value = mat_rd_ff;
         end
         default: ;
      endcase
   end

   a_rate_k: assert property (@(posedge clock) disable iff (reset)
      cmd.pair_hi |=> (k_ff == $past(k_ff) + (RW+1)'(1))) else $error("k");
   a_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.diag_wr |=> (sum_ff == '0)) else $error("sum");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !cmd.pair_lo && !cmd.pair_hi) else $error("clr");

endmodule
`default_nettype wire

@@ hw/rtl/nmer_rate_matrix_builder.sv @@
`default_nettype none
// Rate matrix builder over DNA n-mers (A=0, C=1, G=2, T=3, first base most
// significant). Items enter on req_* (valid/stall) and each gives exactly one
// result item on rsp_* (valid/stall). Configuration writes arrive on csr_*
// (valid/ready, always ready); write them only while the block is idle, which
// the block itself does not enforce. The result of a write or an unused code
// is offered the cycle after the item is taken; a read passes through ST_READ
// before ST_DONE. A marginal fill reads and multiplies the marginal of each
// digit for each of the 4^n n-mers; a build clears the matrix memory, tests
// each (i,j) pair with i<j, writes both entries of each pair one digit apart,
// and then writes minus each row sum to its diagonal entry.
// One item is in flight at a time; req_stall is high while it is worked on
// and while its result waits, so a stalled receiver holds the whole block.
// After reset the rate memory is swept to 0.01, one entry a cycle, over all
// 288 entries with the default maximum length, during which req_stall stays
// high.
module nmer_rate_matrix_builder
   import nmrb_pkg::*;
#(
   parameter int MAX_NMER_LEN = MaxNmerLen
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [ValW-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   nmrb_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   nmrb_datapath #(.MAX_NMER_LEN(MAX_NMER_LEN)) u_dp (
      .clock, .reset, .req_data, .csr_valid, .csr_ready, .csr_index,
      .csr_data, .cmd, .sts, .rsp_data
   );

endmodule
`default_nettype wire
